/* rtl/core/vge_pkg.sv */
package vge_pkg;

    // Largest volume footprint held in the plane store.
    localparam int MAX_X = 256;
    localparam int MAX_Y = 256;

    localparam int COL_W     = $clog2(MAX_X);
    localparam int ROW_W     = $clog2(MAX_Y);
    localparam int ADDR_W    = 1 + ROW_W + COL_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam int SIZE_W = 9;
    localparam int SAMP_W = 16;
    localparam int SQ_W   = 32;
    localparam int DD_W   = 34;
    localparam int RHS_W  = 48;
    localparam int NSTEP  = 8;

    // Output queue between the arithmetic pipeline and the result port.
    localparam int QDEPTH = 32;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int QDATA_W = 33;

    typedef enum logic [1:0] {
        REG_SIZE_X   = 2'd0,
        REG_SIZE_Y   = 2'd1,
        REG_OUT_MODE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic              out_mode;
    } cfg_t;

    // Neighborhood read out of the plane store for one voxel.
    typedef struct packed {
        logic              vld;
        logic              act;
        logic              mode;
        logic              last;
        logic [SAMP_W-1:0] samp;
        logic [SAMP_W-1:0] cen;
        logic [SAMP_W-1:0] xp;
        logic [SAMP_W-1:0] xm;
        logic [SAMP_W-1:0] yp;
        logic [SAMP_W-1:0] ym;
        logic [SAMP_W-1:0] blw;
    } rd_t;

    // One voxel moving through the encoding search.
    typedef struct packed {
        logic                   vld;
        logic                   mode;
        logic                   last;
        logic [7:0]             dens;
        logic [DD_W-1:0]        dd;
        logic [2:0]             dneg;
        logic [2:0][RHS_W-1:0]  rhs;
        logic [2:0][7:0]        kn;
        logic [7:0]             km;
    } srch_t;

    typedef struct packed {
        logic        vld;
        logic        last;
        logic [31:0] data;
    } res_t;

    function automatic logic [COL_W:0] eff_x(input logic [SIZE_W-1:0] sz);
        logic [COL_W:0] r;
        if (sz == '0)
            r = (COL_W+1)'(1);
        else if (int'(sz) > MAX_X)
            r = (COL_W+1)'(MAX_X);
        else
            r = (COL_W+1)'(sz);
        return r;
    endfunction

    function automatic logic [ROW_W:0] eff_y(input logic [SIZE_W-1:0] sz);
        logic [ROW_W:0] r;
        if (sz == '0)
            r = (ROW_W+1)'(1);
        else if (int'(sz) > MAX_Y)
            r = (ROW_W+1)'(MAX_Y);
        else
            r = (ROW_W+1)'(sz);
        return r;
    endfunction

endpackage

/* rtl/core/vge_front.sv */
module vge_front
    import vge_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              act,
    input  logic [SAMP_W-1:0] samp,
    input  cfg_t              cfg,
    output logic              emits,
    output rd_t               rd
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             fpd_reg, fpd_next;
    logic             oof_reg, oof_next;
    logic             slot_reg, slot_next;

    logic [COL_W:0]   sx, col_inc;
    logic [ROW_W:0]   sy, row_inc;
    logic [COL_W-1:0] xp, xm;
    logic [ROW_W-1:0] yp, ym;
    logic             wrap_c, end_p, advance, we, blw_slot, last;
    logic [ADDR_W-1:0] a_wr, a_cen, a_blw, a_xp, a_xm, a_yp, a_ym;

    // Three copies of the store, each read at two places per voxel.
    logic [SAMP_W-1:0] mem_a [MEM_DEPTH];
    logic [SAMP_W-1:0] mem_b [MEM_DEPTH];
    logic [SAMP_W-1:0] mem_c [MEM_DEPTH];

    logic [SAMP_W-1:0] cen_reg, blw_reg, xp_reg, xm_reg, yp_reg, ym_reg, samp_reg;
    logic              vld_reg, act_reg, mode_reg, last_reg;

    always_comb
    begin
        sx      = eff_x(cfg.size_x);
        sy      = eff_y(cfg.size_y);
        col_inc = {1'b0, col_reg} + 1'b1;
        row_inc = {1'b0, row_reg} + 1'b1;
        wrap_c  = (col_inc >= sx);
        end_p   = wrap_c && (row_inc >= sy);
        xp      = (col_inc < sx) ? col_inc[COL_W-1:0] : col_reg;
        xm      = (col_reg != '0) ? col_reg - 1'b1 : col_reg;
        yp      = (row_inc < sy) ? row_inc[ROW_W-1:0] : row_reg;
        ym      = (row_reg != '0) ? row_reg - 1'b1 : row_reg;
        emits   = fpd_reg;
        blw_slot = oof_reg ? ~slot_reg : slot_reg;
        we      = accept && !act;
        advance = accept && (fpd_reg || !act);
        last    = fpd_reg && act && end_p;

        a_wr  = {slot_reg, row_reg, col_reg};
        a_cen = {~slot_reg, row_reg, col_reg};
        a_blw = {blw_slot, row_reg, col_reg};
        a_xp  = {~slot_reg, row_reg, xp};
        a_xm  = {~slot_reg, row_reg, xm};
        a_yp  = {~slot_reg, yp, col_reg};
        a_ym  = {~slot_reg, ym, col_reg};

        col_next  = col_reg;
        row_next  = row_reg;
        fpd_next  = fpd_reg;
        oof_next  = oof_reg;
        slot_next = slot_reg;
        if (advance)
        begin
            if (wrap_c)
            begin
                col_next = '0;
                row_next = end_p ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
            if (end_p)
            begin
                if (!fpd_reg)
                begin
                    fpd_next  = 1'b1;
                    slot_next = ~slot_reg;
                end
                else if (!act)
                begin
                    slot_next = ~slot_reg;
                    oof_next  = 1'b0;
                end
                else
                begin
                    col_next  = '0;
                    row_next  = '0;
                    fpd_next  = 1'b0;
                    oof_next  = 1'b1;
                    slot_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            fpd_reg  <= 1'b0;
            oof_reg  <= 1'b1;
            slot_reg <= 1'b0;
            vld_reg  <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            fpd_reg  <= fpd_next;
            oof_reg  <= oof_next;
            slot_reg <= slot_next;
            vld_reg  <= accept && fpd_reg;
        end
    end

    // Reads see the store as it stood before this voxel's own write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_a[a_wr] <= samp;
            mem_b[a_wr] <= samp;
            mem_c[a_wr] <= samp;
        end
        if (accept)
        begin
            cen_reg  <= mem_a[a_cen];
            blw_reg  <= mem_a[a_blw];
            xp_reg   <= mem_b[a_xp];
            xm_reg   <= mem_b[a_xm];
            yp_reg   <= mem_c[a_yp];
            ym_reg   <= mem_c[a_ym];
            samp_reg <= samp;
            act_reg  <= act;
            mode_reg <= cfg.out_mode;
            last_reg <= last;
        end
    end

    always_comb
    begin
        rd.vld  = vld_reg;
        rd.act  = act_reg;
        rd.mode = mode_reg;
        rd.last = last_reg;
        rd.samp = samp_reg;
        rd.cen  = cen_reg;
        rd.xp   = xp_reg;
        rd.xm   = xm_reg;
        rd.yp   = yp_reg;
        rd.ym   = ym_reg;
        rd.blw  = blw_reg;
    end

endmodule

/* rtl/core/vge_step.sv */
module vge_step
    import vge_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] bitm,
    input  srch_t      s_in,
    output srch_t      s_out
);

    srch_t            a_reg, b_reg, c_reg, c_next;
    logic [2:0][14:0] u2_reg;
    logic [17:0]      csq_reg;
    logic [2:0][31:0] pl_reg, ph_reg;
    logic [34:0]      mq_reg;

    logic [2:0][7:0]  kt, ua, kc;
    logic [2:0][15:0] u2f;
    logic [2:0][14:0] u2;
    logic [7:0]       cm;
    logic [8:0]       cv;
    logic [17:0]      csq;
    logic [2:0][31:0] pl, ph;
    logic [34:0]      mq;
    logic [2:0][48:0] lp;
    logic [2:0]       fits;
    logic [50:0]      lhs;
    logic [50:0]      rhs;
    logic             tpos;

    // Trial code squared: u = k - 128, and |2k - 256|^2 = 4u^2.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            kt[i]  = s_in.kn[i] | bitm;
            ua[i]  = kt[i][7] ? {1'b0, kt[i][6:0]} : 8'd128 - kt[i];
            u2f[i] = ua[i] * ua[i];
            u2[i]  = u2f[i][14:0];
        end
        cm  = s_in.km | bitm;
        cv  = {cm, 1'b0} - 9'd1;
        csq = {9'b0, cv} * {9'b0, cv};
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pl[i] = {17'b0, u2_reg[i]} * {15'b0, a_reg.dd[16:0]};
            ph[i] = {17'b0, u2_reg[i]} * {15'b0, a_reg.dd[33:17]};
        end
        mq = {17'b0, csq_reg} * 35'd66049;
    end

    always_comb
    begin
        c_next = b_reg;
        for (int i = 0; i < 3; i++)
        begin
            kc[i] = b_reg.kn[i] | bitm;
            lp[i] = {ph_reg[i], 17'b0} + {17'b0, pl_reg[i]};
            lhs   = {lp[i], 2'b00};
            rhs   = {3'b0, b_reg.rhs[i]};
            tpos  = (kc[i] > 8'd128);
            if (!tpos && !b_reg.dneg[i])
                fits[i] = 1'b1;
            else if (tpos && b_reg.dneg[i])
                fits[i] = 1'b0;
            else if (tpos)
                fits[i] = (lhs <= rhs);
            else
                fits[i] = (lhs >= rhs);
            if (fits[i])
                c_next.kn[i] = kc[i];
        end
        if ({1'b0, mq_reg} <= {b_reg.dd, 2'b00})
            c_next.km = b_reg.km | bitm;
        else
            c_next.km = b_reg.km;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
        end
        else
        begin
            a_reg <= s_in;
            b_reg <= a_reg;
            c_reg <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u2_reg  <= u2;
        csq_reg <= csq;
        pl_reg  <= pl;
        ph_reg  <= ph;
        mq_reg  <= mq;
    end

    assign s_out = c_reg;

endmodule

/* rtl/core/vge_back.sv */
module vge_back
    import vge_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  rd_t  rd,
    output res_t res
);

    typedef struct packed {
        logic               vld;
        logic               mode;
        logic               last;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [16:0] dz;
        logic [16:0]        y;
        logic [7:0]         qe;
    } b1_t;

    typedef struct packed {
        logic            vld;
        logic            mode;
        logic            last;
        logic [7:0]      dens;
        logic [2:0]      dneg;
        logic [2:0][SQ_W-1:0] sq;
    } b2_t;

    b1_t   b1_reg, b1_next;
    b2_t   b2_reg, b2_next;
    srch_t b3_reg, b3_next;
    res_t  res_reg, res_next;
    srch_t chain [NSTEP+1];

    logic [SAMP_W-1:0]    above;
    logic [24:0]          p255;
    logic [16:0]          rem;
    logic [2:0][16:0]     dv, dabs;
    logic                 dzero;
    srch_t                fin;

    // Difference vector and density quotient estimate.
    always_comb
    begin
        above        = rd.act ? rd.cen : rd.samp;
        b1_next.vld  = rd.vld;
        b1_next.mode = rd.mode;
        b1_next.last = rd.last;
        b1_next.dx   = $signed({1'b0, rd.xp}) - $signed({1'b0, rd.xm});
        b1_next.dy   = $signed({1'b0, rd.yp}) - $signed({1'b0, rd.ym});
        b1_next.dz   = $signed({1'b0, above}) - $signed({1'b0, rd.blw});
        b1_next.y    = {1'b0, rd.cen} + 17'd128;
        p255         = {b1_next.y, 8'b0} - {8'b0, b1_next.y};
        b1_next.qe   = p255[23:16];
    end

    // Density byte is floor((c + 128) / 257); the estimate is low by at most one.
    always_comb
    begin
        rem          = b1_reg.y - ({1'b0, b1_reg.qe, 8'b0} + {9'b0, b1_reg.qe});
        b2_next.vld  = b1_reg.vld;
        b2_next.mode = b1_reg.mode;
        b2_next.last = b1_reg.last;
        b2_next.dens = (rem >= 17'd257) ? b1_reg.qe + 8'd1 : b1_reg.qe;
        dv[0] = b1_reg.dx;
        dv[1] = b1_reg.dy;
        dv[2] = b1_reg.dz;
        for (int i = 0; i < 3; i++)
        begin
            b2_next.dneg[i] = dv[i][16];
            dabs[i]         = dv[i][16] ? 17'd0 - dv[i] : dv[i];
            b2_next.sq[i]   = {16'b0, dabs[i][15:0]} * {16'b0, dabs[i][15:0]};
        end
    end

    always_comb
    begin
        b3_next.vld  = b2_reg.vld;
        b3_next.mode = b2_reg.mode;
        b3_next.last = b2_reg.last;
        b3_next.dens = b2_reg.dens;
        b3_next.dneg = b2_reg.dneg;
        b3_next.dd   = {2'b0, b2_reg.sq[0]} + {2'b0, b2_reg.sq[1]} + {2'b0, b2_reg.sq[2]};
        for (int i = 0; i < 3; i++)
            b3_next.rhs[i] = {16'b0, b2_reg.sq[i]} * 48'd65025;
        b3_next.kn = '0;
        b3_next.km = '0;
    end

    assign chain[0] = b3_reg;

    // One code bit per step, most significant first.
    for (genvar g = 0; g < NSTEP; g++)
    begin : g_step
        vge_step u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .bitm  (8'(1 << (NSTEP - 1 - g))),
            .s_in  (chain[g]),
            .s_out (chain[g+1])
        );
    end

    always_comb
    begin
        fin           = chain[NSTEP];
        dzero         = (fin.dd == '0);
        res_next.vld  = fin.vld;
        res_next.last = fin.last;
        if (!fin.mode)
        begin
            res_next.data[7:0]   = dzero ? 8'd128 : fin.kn[0];
            res_next.data[15:8]  = dzero ? 8'd128 : fin.kn[1];
            res_next.data[23:16] = dzero ? 8'd128 : fin.kn[2];
            res_next.data[31:24] = fin.dens;
        end
        else
        begin
            res_next.data[7:0]   = fin.dens;
            res_next.data[15:8]  = fin.km;
            res_next.data[31:16] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg  <= '0;
            b2_reg  <= '0;
            b3_reg  <= '0;
            res_reg <= '0;
        end
        else
        begin
            b1_reg  <= b1_next;
            b2_reg  <= b2_next;
            b3_reg  <= b3_next;
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/core/vge_fifo.sv */
module vge_fifo
    import vge_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [QDATA_W-1:0] wr_data,
    input  logic               rd_en,
    output logic [QDATA_W-1:0] rd_data,
    output logic               not_empty
);

    logic [QDATA_W-1:0] q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wp_reg, rp_reg;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_reg[wp_reg] <= wr_data;
    end

    assign rd_data   = q_reg[rp_reg];
    assign not_empty = (cnt_reg != '0);

endmodule

/* rtl/core/volume_gradient_encoder_unit.sv */
// Central-difference gradient encoder for a voxel stream.
//
// Voxels enter on the s_axis channel in raster order, x fastest: tuser is 0
// for a voxel, whose 16-bit density fraction is in tdata, and 1 for a drain
// transaction. After the last voxel the feeder sends one plane of drain
// transactions. Results leave on m_axis as four bytes in tdata, with tlast
// marking the result of the final voxel of the volume.
// The first plane only fills the store; from then on each transaction of
// plane z+1 (or of the drain plane) yields the result of the voxel at the
// same position in plane z. One transaction is taken every cycle while
// s_axis_tready is high; the rate is set by the plane store, which is read
// at six places per cycle through three copies with two read ports each.
// A 32-entry result queue absorbs stalls of the receiver; tready falls only
// when every place in the queue is spoken for by results in flight.
// Registers (APB): 0x0 size_x, 0x4 size_y, 0x8 out_mode; write them only
// while the block is idle. Reset clears positions and sets sizes to 256 and
// mode to 0; the store contents are undefined and need no clearing pass.
module volume_gradient_encoder_unit
    import vge_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tuser,   // [0] action
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] chan_r, [15:8] chan_g, [23:16] chan_b,
                                        // [31:24] chan_a (out_mode 0)
    output logic        m_axis_tlast    // last_voxel
);

    cfg_t              cfg_reg;
    reg_idx_t          ridx;
    logic              cfg_wr;
    logic              s_acc, m_acc, emits;
    logic [QCNT_W-1:0] occ_reg, occ_next;
    rd_t               rd;
    res_t              res;
    logic [QDATA_W-1:0] q_out;

    assign pready = 1'b1;
    assign ridx   = reg_idx_t'(paddr[3:2]);
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_x   <= SIZE_W'(256);
            cfg_reg.size_y   <= SIZE_W'(256);
            cfg_reg.out_mode <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (ridx)
                REG_SIZE_X:   cfg_reg.size_x   <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y:   cfg_reg.size_y   <= pwdata[SIZE_W-1:0];
                REG_OUT_MODE: cfg_reg.out_mode <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_SIZE_X:   prdata = {{(32-SIZE_W){1'b0}}, cfg_reg.size_x};
            REG_SIZE_Y:   prdata = {{(32-SIZE_W){1'b0}}, cfg_reg.size_y};
            REG_OUT_MODE: prdata = {31'b0, cfg_reg.out_mode};
            default:      prdata = '0;
        endcase
    end

    // occ_reg counts results promised but not yet delivered, whether they
    // are still in the pipeline or waiting in the queue. Keeping it at or below
    // the queue depth means the pipeline never has to stall.
    assign s_axis_tready = (occ_reg < QCNT_W'(QDEPTH));
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_acc         = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        occ_next = occ_reg;
        if ((s_acc && emits) && !m_acc)
            occ_next = occ_reg + 1'b1;
        else if (!(s_acc && emits) && m_acc)
            occ_next = occ_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    vge_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (s_acc),
        .act    (s_axis_tuser),
        .samp   (s_axis_tdata),
        .cfg    (cfg_reg),
        .emits  (emits),
        .rd     (rd)
    );

    vge_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (rd),
        .res   (res)
    );

    vge_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (res.vld),
        .wr_data   ({res.last, res.data}),
        .rd_en     (m_acc),
        .rd_data   (q_out),
        .not_empty (m_axis_tvalid)
    );

    assign m_axis_tdata = q_out[31:0];
    assign m_axis_tlast = q_out[32];

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= QCNT_W'(QDEPTH))
        else $error("result credit count above queue depth");

    a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (occ_reg != '0))
        else $error("queued result without an outstanding credit");

    a_pipe_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        res.vld |-> (occ_reg != '0))
        else $error("pipeline result without an outstanding credit");

    a_read_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        rd.vld |-> $past(s_acc))
        else $error("store read out without an accepted transaction");

endmodule
